>>> hw/rtl/sor_pkg.sv
// ----------------------------------------------------------------------------
// Spiral order reader package
// Shared widths, register indexes, edge phase codes and the command struct
// that the controller hands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package sor_pkg;

   // Width of a dimension register and of row, column and layer counters.
   localparam int DIM_W = 5;
   // Width of a row-major linear position (rows times columns).
   localparam int PROD_W = 2 * DIM_W;
   // Width of the row and column fields of a result.
   localparam int POS_W = 4;
   // Width of the edge phase code.
   localparam int PHASE_W = 3;

   // Configuration port.
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = DIM_W;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COL_COUNT = 2'd1;

   // Edge phases of the spiral walk.
   localparam logic [PHASE_W-1:0] PH_TOP    = 3'd0;
   localparam logic [PHASE_W-1:0] PH_RIGHT  = 3'd1;
   localparam logic [PHASE_W-1:0] PH_BOTTOM = 3'd2;
   localparam logic [PHASE_W-1:0] PH_LEFT   = 3'd3;
   localparam logic [PHASE_W-1:0] PH_CENTER = 3'd4;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;     // write the request value and advance the load pointer
      logic fetch;    // start a memory read and advance the spiral position
      logic capture;  // move read data and position into the result register
   } sor_cmd_type;

endpackage

`default_nettype wire

>>> hw/rtl/sor_if.sv
// ----------------------------------------------------------------------------
// Spiral order reader channel interfaces
// Valid/ready channels for requests, responses and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

// Request channel: load or fetch items.
interface sor_req_if #(
   parameter int DATA_WIDTH = 32
);
   logic                         valid;
   logic                         ready;
   logic                         op;
   logic signed [DATA_WIDTH-1:0] value;

   modport source (output valid, output op, output value, input ready);
   modport sink   (input valid, input op, input value, output ready);
endinterface

// Response channel: one spiral element per fetch.
interface sor_rsp_if #(
   parameter int DATA_WIDTH = 32
);
   import sor_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] elem_value;
   logic [POS_W-1:0]             elem_row;
   logic [POS_W-1:0]             elem_col;
   logic                         last;

   modport source (output valid, output elem_value, output elem_row, output elem_col,
                   output last, input ready);
   modport sink   (input valid, input elem_value, input elem_row, input elem_col,
                   input last, output ready);
endinterface

// Register write channel.
interface sor_csr_if;
   import sor_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/sor_ram.sv
// ----------------------------------------------------------------------------
// Spiral order reader RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sor_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; read data holds between reads.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/sor_ctrl.sv
// ----------------------------------------------------------------------------
// Spiral order reader controller
// Sequences request transfers, the memory read of a fetch and the result
// register's valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module sor_ctrl (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire logic         req_op,
   output logic              req_ready,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output sor_pkg::sor_cmd_type cmd
);
   import sor_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_READ = 1'b1;

   logic state_ff;
   logic state_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic out_free;
   logic accept;

   // The result register can take new data when empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_ready;

   // A new item may enter while the previous read completes into the result.
   assign req_ready = (state_ff == ST_IDLE) || out_free;
   assign accept = req_valid && req_ready;

   // Commands for the datapath.
   always_comb begin
      cmd.load = accept && !req_op;
      cmd.fetch = accept && req_op;
      cmd.capture = (state_ff == ST_READ) && out_free;
   end

   // Next state and result valid flag.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.fetch) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (out_free) begin
               state_in = cmd.fetch ? ST_READ : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cmd.capture) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // A fetch always leaves a read in flight for the next cycle.
   a_fetch_reads: assert property (@(posedge clock) disable iff (reset)
      cmd.fetch |=> (state_ff == ST_READ))
      else $error("fetch transfer did not start a memory read");

   // A load taken while idle never starts a read.
   a_load_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && cmd.load) |=> (state_ff == ST_IDLE))
      else $error("load transfer started a memory read");

   // A result only appears after read data was captured.
   a_valid_from_capture: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.capture))
      else $error("response valid without captured read data");

endmodule

`default_nettype wire

>>> hw/rtl/sor_datapath.sv
// ----------------------------------------------------------------------------
// Spiral order reader datapath
// Dimension registers, load pointer, spiral position, element memory and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sor_datapath #(
   parameter int MAX_DIM = 16,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire sor_pkg::sor_cmd_type          cmd,
   input  wire logic signed [DATA_WIDTH-1:0]  req_value,
   input  wire logic                          csr_valid,
   input  wire logic [sor_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [sor_pkg::CSR_DATA_W-1:0] csr_data,
   output logic signed [DATA_WIDTH-1:0]       elem_value,
   output logic [sor_pkg::POS_W-1:0]          elem_row,
   output logic [sor_pkg::POS_W-1:0]          elem_col,
   output logic                               last
);
   import sor_pkg::*;

   localparam int Depth = MAX_DIM * MAX_DIM;
   localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int DimCapInt = (MAX_DIM < 31) ? MAX_DIM : 31;
   localparam logic [DIM_W-1:0] DIM_CAP = DIM_W'(DimCapInt);
   localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(16);

   // Configuration registers.
   logic [DIM_W-1:0] row_count_ff;
   logic [DIM_W-1:0] col_count_ff;

   // Load pointer and spiral position.
   logic [PROD_W-1:0]  load_ptr_ff;
   logic [PROD_W-1:0]  load_ptr_in;
   logic [DIM_W-1:0]   layer_ff;
   logic [DIM_W-1:0]   layer_in;
   logic [PHASE_W-1:0] phase_ff;
   logic [PHASE_W-1:0] phase_in;
   logic [DIM_W-1:0]   index_ff;
   logic [DIM_W-1:0]   index_in;

   // Position of the read in flight.
   logic [DIM_W-1:0] pend_row_ff;
   logic [DIM_W-1:0] pend_col_ff;
   logic             pend_last_ff;

   // Result register.
   logic signed [DATA_WIDTH-1:0] out_value_ff;
   logic [POS_W-1:0]             out_row_ff;
   logic [POS_W-1:0]             out_col_ff;
   logic                         out_last_ff;

   // Derived dimensions.
   logic [DIM_W-1:0]  rows;
   logic [DIM_W-1:0]  cols;
   logic [PROD_W-1:0] total;
   logic [DIM_W-1:0]  min_dim;
   logic [DIM_W-1:0]  num_layers;
   logic              min_odd;
   logic [PHASE_W-1:0] start_phase;

   // Spiral step signals.
   logic               held_ok;
   logic [DIM_W-1:0]   held_len;
   logic [DIM_W-1:0]   eff_layer;
   logic [PHASE_W-1:0] eff_phase;
   logic [DIM_W-1:0]   eff_index;
   logic [DIM_W-1:0]   eff_len;
   logic [DIM_W-1:0]   pos_row;
   logic [DIM_W-1:0]   pos_col;
   logic [DIM_W-1:0]   index_next;
   logic [DIM_W-1:0]   layer_next;
   logic               edge_done;
   logic               step_last;
   logic [PROD_W-1:0]  rd_pos;

   // Load pointer signals.
   logic [PROD_W-1:0] wr_pos;
   logic [PROD_W-1:0] wr_pos_next;

   // Memory read data.
   logic [DATA_WIDTH-1:0] rd_data;

   // A dimension of zero counts as one; large values saturate at the maximum.
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
      logic [DIM_W-1:0] res;
      res = d;
      if (d == '0) begin
         res = DIM_W'(1);
      end else if (d > DIM_CAP) begin
         res = DIM_CAP;
      end
      return res;
   endfunction

   // Number of elements on one edge phase of one layer.
   function automatic logic [DIM_W-1:0] edge_len(input logic [DIM_W-1:0] r_dim,
                                                 input logic [DIM_W-1:0] c_dim,
                                                 input logic [PHASE_W-1:0] ph,
                                                 input logic [DIM_W-1:0] lyr);
      logic [DIM_W-1:0] dbl;
      logic [DIM_W-1:0] res;
      dbl = {lyr[DIM_W-2:0], 1'b0};
      case (ph)
         PH_TOP, PH_BOTTOM: res = c_dim - dbl - DIM_W'(1);
         PH_RIGHT, PH_LEFT: res = r_dim - dbl - DIM_W'(1);
         default:           res = (r_dim > c_dim) ? (r_dim - dbl) : (c_dim - dbl);
      endcase
      return res;
   endfunction

   // Register writes; an unknown index is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= DIM_RESET;
         col_count_ff <= DIM_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_ROW_COUNT: row_count_ff <= csr_data;
            REG_COL_COUNT: col_count_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Effective dimensions and layer count.
   always_comb begin
      rows = clamp_dim(row_count_ff);
      cols = clamp_dim(col_count_ff);
      total = PROD_W'(rows) * PROD_W'(cols);
      min_dim = (rows < cols) ? rows : cols;
      num_layers = min_dim >> 1;
      min_odd = min_dim[0];
      start_phase = (num_layers == '0) ? PH_CENTER : PH_TOP;
   end

   // Load pointer: restart if it lies beyond the matrix, wrap after the end.
   always_comb begin
      wr_pos = (load_ptr_ff >= total) ? '0 : load_ptr_ff;
      wr_pos_next = wr_pos + PROD_W'(1);
      load_ptr_in = (wr_pos_next >= total) ? '0 : wr_pos_next;
   end

   // Check the held position against the current dimensions.
   always_comb begin
      held_len = edge_len(rows, cols, phase_ff, layer_ff);
      if (phase_ff < PH_CENTER) begin
         held_ok = layer_ff < num_layers;
      end else if (phase_ff == PH_CENTER) begin
         held_ok = min_odd && (layer_ff == num_layers);
      end else begin
         held_ok = 1'b0;
      end
      held_ok = held_ok && (index_ff < held_len);

      if (held_ok) begin
         eff_layer = layer_ff;
         eff_phase = phase_ff;
         eff_index = index_ff;
      end else begin
         eff_layer = '0;
         eff_phase = start_phase;
         eff_index = '0;
      end
   end

   // Row and column of the current spiral element.
   always_comb begin
      case (eff_phase)
         PH_TOP: begin
            pos_row = eff_layer;
            pos_col = eff_layer + eff_index;
         end
         PH_RIGHT: begin
            pos_row = eff_layer + eff_index;
            pos_col = cols - eff_layer - DIM_W'(1);
         end
         PH_BOTTOM: begin
            pos_row = rows - eff_layer - DIM_W'(1);
            pos_col = cols - eff_layer - DIM_W'(1) - eff_index;
         end
         PH_LEFT: begin
            pos_row = rows - eff_layer - DIM_W'(1) - eff_index;
            pos_col = eff_layer;
         end
         default: begin
            if (rows > cols) begin
               pos_row = eff_layer + eff_index;
               pos_col = eff_layer;
            end else begin
               pos_row = eff_layer;
               pos_col = eff_layer + eff_index;
            end
         end
      endcase
      rd_pos = (PROD_W'(pos_row) * PROD_W'(cols)) + PROD_W'(pos_col);
   end

   // Advance along the edge, then to the next edge, layer or center line.
   always_comb begin
      eff_len = edge_len(rows, cols, eff_phase, eff_layer);
      index_next = eff_index + DIM_W'(1);
      layer_next = eff_layer + DIM_W'(1);
      edge_done = index_next >= eff_len;
      step_last = 1'b0;
      layer_in = eff_layer;
      phase_in = eff_phase;
      index_in = index_next;

      if (edge_done) begin
         index_in = '0;
         if (eff_phase == PH_CENTER) begin
            step_last = 1'b1;
         end else if (eff_phase == PH_LEFT) begin
            layer_in = layer_next;
            if (layer_next >= num_layers) begin
               if (min_odd) begin
                  phase_in = PH_CENTER;
               end else begin
                  step_last = 1'b1;
               end
            end else begin
               phase_in = PH_TOP;
            end
         end else begin
            phase_in = eff_phase + PHASE_W'(1);
         end
      end

      // The spiral starts over after its final element.
      if (step_last) begin
         layer_in = '0;
         phase_in = start_phase;
         index_in = '0;
      end
   end

   // Control state: load pointer and spiral position.
   always_ff @(posedge clock) begin
      if (reset) begin
         load_ptr_ff <= '0;
         layer_ff <= '0;
         phase_ff <= PH_TOP;
         index_ff <= '0;
      end else begin
         if (cmd.load) begin
            load_ptr_ff <= load_ptr_in;
         end
         if (cmd.fetch) begin
            layer_ff <= layer_in;
            phase_ff <= phase_in;
            index_ff <= index_in;
         end
      end
   end

   // Position of the read in flight, then the result register.
   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         pend_row_ff <= pos_row;
         pend_col_ff <= pos_col;
         pend_last_ff <= step_last;
      end
      if (cmd.capture) begin
         out_value_ff <= rd_data;
         out_row_ff <= pend_row_ff[POS_W-1:0];
         out_col_ff <= pend_col_ff[POS_W-1:0];
         out_last_ff <= pend_last_ff;
      end
   end

   // Element memory.
   sor_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (Depth)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.load),
      .wr_addr (AddrW'(wr_pos)),
      .wr_data (req_value),
      .rd_en   (cmd.fetch),
      .rd_addr (AddrW'(rd_pos)),
      .rd_data (rd_data)
   );

   assign elem_value = out_value_ff;
   assign elem_row = out_row_ff;
   assign elem_col = out_col_ff;
   assign last = out_last_ff;

   // A fetch always leaves a legal edge phase behind.
   a_phase_legal: assert property (@(posedge clock) disable iff (reset)
      cmd.fetch |=> (phase_ff <= PH_CENTER))
      else $error("spiral phase left the legal range");

   // After the final element the walk is back at its start.
   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      cmd.fetch |=> (!pend_last_ff || (layer_ff == '0 && index_ff == '0)))
      else $error("spiral did not restart after its final element");

   // The load pointer stays inside the matrix.
   a_load_ptr_range: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (load_ptr_ff < $past(total)))
      else $error("load pointer beyond the matrix");

endmodule

`default_nettype wire

>>> hw/rtl/spiral_order_reader_core.sv
// ----------------------------------------------------------------------------
// Spiral order reader core
// Holds a matrix loaded in row-major order and reads it out in clockwise
// spiral order, one element per fetch.
// ----------------------------------------------------------------------------
// Usage:
// - req_chan carries items. op 0 writes value at the load pointer, which walks
//   the matrix row by row and wraps at the end; it produces no response.
//   op 1 fetches the next spiral element.
// - rsp_chan returns one transfer per fetch: the element value, its row and
//   column, and last on the final element of the spiral, after which the
//   spiral starts over.
// - csr_chan writes row_count (index 0) and col_count (index 1); it is always
//   ready. Write it only while no fetch is outstanding.
// - A fetch response passes through the memory read register, loaded at the
//   transfer edge, and then the result register, loaded once it is free.
// - Loads and fetches are taken at one per cycle while the response side keeps
//   up; the single read port of the element memory bounds this.
// - When rsp_chan stalls, the result is held and one more fetch may enter; the
//   request side then stalls until the result register frees up.
// - Reset sets both dimensions to 16 and the load pointer and spiral position
//   to the start. The memory is not cleared; load entries before fetching them.
// ----------------------------------------------------------------------------
`default_nettype none

module spiral_order_reader_core #(
   parameter int MAX_DIM = 16,
   parameter int DATA_WIDTH = 32
) (
   input wire logic  clock,
   input wire logic  reset,
   sor_req_if.sink   req_chan,
   sor_rsp_if.source rsp_chan,
   sor_csr_if.sink   csr_chan
);
   import sor_pkg::*;

   sor_cmd_type cmd;

   // Register writes are taken in any cycle.
   assign csr_chan.ready = 1'b1;

   // Handshake sequencing.
   sor_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_op    (req_chan.op),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   // Matrix storage and spiral walk.
   sor_datapath #(
      .MAX_DIM    (MAX_DIM),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_value  (req_chan.value),
      .csr_valid  (csr_chan.valid),
      .csr_index  (csr_chan.index),
      .csr_data   (csr_chan.data),
      .elem_value (rsp_chan.elem_value),
      .elem_row   (rsp_chan.elem_row),
      .elem_col   (rsp_chan.elem_col),
      .last       (rsp_chan.last)
   );

endmodule

`default_nettype wire
